// ----- design/rxrfe_pkg.sv -----
// Shared constants and types for the receive ring head-pointer manager.
package rxrfe_pkg;

    localparam int RING_BASE  = 18432;
    localparam int RING_BYTES = 6144;
    localparam int MAX_FRAME  = 1514;
    localparam int THRESH_RST = 1528;

    localparam int PTR_W    = 16;
    localparam int LEN_W    = 11;
    localparam int THRESH_W = 13;
    localparam int CNT_W    = 32;
    localparam int SPAN_W   = PTR_W + 1;   // room for ring end and head + size
    localparam int NEED_W   = LEN_W + 1;

    localparam logic [PTR_W-1:0]    BASE_PTR  = PTR_W'(RING_BASE);
    localparam logic [SPAN_W-1:0]   BASE_SPAN = SPAN_W'(RING_BASE);
    localparam logic [SPAN_W-1:0]   END_SPAN  = SPAN_W'(RING_BASE + RING_BYTES);
    localparam logic [SPAN_W-1:0]   END_M2    = SPAN_W'(RING_BASE + RING_BYTES - 2);
    localparam logic [SPAN_W-1:0]   BYTES_SPAN = SPAN_W'(RING_BYTES);
    localparam logic [LEN_W-1:0]    MAX_LEN   = LEN_W'(MAX_FRAME);
    localparam logic [THRESH_W-1:0] THRESH_INIT = THRESH_W'(THRESH_RST);

    typedef enum logic [0:0] {
        FUNC_STATUS  = 1'b0,
        FUNC_ENQUEUE = 1'b1
    } t_func;

    // reset-sequence tracker: zero means not yet sampled, else bit + 1
    localparam logic [1:0] SEQ_UNSEEN = 2'd0;

endpackage

// ----- design/rx_ring_frame_enqueue.sv -----
// Receive ring head-pointer manager: frame placement and status tracking.
// Request path: input register, one pass of compare-and-update logic, then result
// register.
// Throughput: one request per cycle; input stalls only while a stalled result
// and a full input register are both held.
// Synchronous active-low reset: head at ring base, counters and flags clear,
// wrap threshold back to its default of 1528 bytes.
module rx_ring_frame_enqueue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [rxrfe_pkg::PTR_W-1:0]       i_tail_ptr,
    input  logic                              i_rx_enable,
    input  logic                              i_reset_seq,
    input  logic [rxrfe_pkg::LEN_W-1:0]       i_frame_len,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_accepted,
    output logic [rxrfe_pkg::PTR_W-1:0]       o_write_addr,
    output logic [31:0]                       o_header_word,
    output logic [rxrfe_pkg::PTR_W-1:0]       o_head_pos,
    output logic [rxrfe_pkg::CNT_W-1:0]       o_frame_count,
    output logic                              o_ring_restarted,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rxrfe_pkg::THRESH_W-1:0]    i_cfg_data
);
    import rxrfe_pkg::*;

    // input register
    logic                r_in_vld;
    logic                r_in_func;
    logic [PTR_W-1:0]    r_in_tail;
    logic                r_in_en;
    logic                r_in_rseq;
    logic [LEN_W-1:0]    r_in_len;

    // ring state
    logic [PTR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_tmoved, n_tmoved;
    logic                r_prev_en, n_prev_en;
    logic                r_drop, n_drop;
    logic [1:0]          r_seen, n_seen;
    logic [THRESH_W-1:0] r_thresh;

    // result register
    logic                r_out_vld;
    logic                r_acc, n_acc;
    logic [PTR_W-1:0]    r_waddr, n_waddr;
    logic [31:0]         r_hdr, n_hdr;
    logic                r_restart, n_restart;

    logic                advance;
    logic                fire;
    logic                is_status;

    // datapath intermediates
    logic [NEED_W-1:0]   need_sum;
    logic [NEED_W-1:0]   need;
    logic [SPAN_W-1:0]   start_s;
    logic [SPAN_W-1:0]   tail_s;
    logic [SPAN_W-1:0]   next_s;
    logic [SPAN_W-1:0]   diff_s;
    logic [SPAN_W-1:0]   free_s;
    logic [PTR_W-1:0]    link_ptr;
    logic                interior;
    logic                len_ok;
    logic                lap_block;
    logic                past_end;
    logic                no_space;
    logic                ok;
    logic [1:0]          seq_p1;
    logic                restart;
    logic [PTR_W-1:0]    h0;
    logic [CNT_W-1:0]    c0;
    logic                tm0, pe0, sd0, tm1, sd1;

    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;
    assign o_cfg_ready = 1'b1;
    assign is_status  = (r_in_func == FUNC_STATUS);

    // padded size: 8 + len rounded up to a multiple of 8
    assign need_sum = {1'b0, r_in_len} + NEED_W'(15);
    assign need     = {need_sum[NEED_W-1:3], 3'b000};

    assign start_s  = {1'b0, r_head};
    assign tail_s   = {1'b0, r_in_tail};
    assign next_s   = start_s + {{(SPAN_W-NEED_W){1'b0}}, need};
    assign diff_s   = start_s - tail_s;
    assign interior = (tail_s > BASE_SPAN) && (tail_s < END_M2);

    always_comb begin
        if (tail_s >= start_s) begin
            free_s = tail_s - start_s;
        end else if (diff_s > BYTES_SPAN) begin
            free_s = '0;
        end else begin
            free_s = BYTES_SPAN - diff_s;
        end
    end

    assign len_ok    = (r_in_len <= MAX_LEN);
    assign lap_block = (r_head == BASE_PTR) && (r_count != '0) && !(r_tmoved || interior);
    assign past_end  = (next_s > END_SPAN);
    assign no_space  = (free_s < {{(SPAN_W-NEED_W){1'b0}}, need});
    assign ok        = len_ok && !lap_block && !past_end && !no_space;
    assign link_ptr  = ((END_SPAN - next_s) < {{(SPAN_W-THRESH_W){1'b0}}, r_thresh})
                       ? BASE_PTR : next_s[PTR_W-1:0];

    // status path: restart first, then tail and enable tracking
    assign seq_p1  = {1'b0, r_in_rseq} + 2'd1;
    assign restart = (r_seen != SEQ_UNSEEN) && (seq_p1 != r_seen);
    assign h0  = restart ? BASE_PTR : r_head;
    assign c0  = restart ? '0 : r_count;
    assign tm0 = restart ? 1'b0 : r_tmoved;
    assign pe0 = restart ? 1'b0 : r_prev_en;
    assign sd0 = restart ? 1'b0 : r_drop;
    assign tm1 = tm0 || interior;
    assign sd1 = sd0 || (pe0 && !r_in_en && (c0 != '0));

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_tmoved  = r_tmoved;
        n_prev_en = r_prev_en;
        n_drop    = r_drop;
        n_seen    = r_seen;
        n_acc     = 1'b0;
        n_waddr   = '0;
        n_hdr     = '0;
        n_restart = 1'b0;
        if (is_status) begin
            n_seen    = seq_p1;
            n_head    = h0;
            n_count   = c0;
            n_drop    = sd1;
            n_tmoved  = tm1 || (sd1 && r_in_en);
            n_prev_en = r_in_en;
            n_restart = restart;
        end else if (len_ok) begin
            n_tmoved = r_tmoved || interior;
            if (ok) begin
                n_acc   = 1'b1;
                n_waddr = r_head;
                n_hdr   = {{(16-LEN_W){1'b0}}, r_in_len, link_ptr};
                n_head  = link_ptr;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_head    <= BASE_PTR;
            r_count   <= '0;
            r_tmoved  <= 1'b0;
            r_prev_en <= 1'b0;
            r_drop    <= 1'b0;
            r_seen    <= SEQ_UNSEEN;
            r_thresh  <= THRESH_INIT;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (fire) begin
                r_head    <= n_head;
                r_count   <= n_count;
                r_tmoved  <= n_tmoved;
                r_prev_en <= n_prev_en;
                r_drop    <= n_drop;
                r_seen    <= n_seen;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_func <= i_func;
            r_in_tail <= i_tail_ptr;
            r_in_en   <= i_rx_enable;
            r_in_rseq <= i_reset_seq;
            r_in_len  <= i_frame_len;
        end
        if (fire) begin
            r_acc     <= n_acc;
            r_waddr   <= n_waddr;
            r_hdr     <= n_hdr;
            r_restart <= n_restart;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_accepted       = r_acc;
    assign o_write_addr     = r_waddr;
    assign o_header_word    = r_hdr;
    // ring state moves only together with the result register
    assign o_head_pos       = r_head;
    assign o_frame_count    = r_count;
    assign o_ring_restarted = r_restart;

endmodule
